/* src/pwsd_pkg.sv */
// pwsd_pkg: types, constants and register codes of the pulse width symbol decoder
// used by the interfaces and all modules under src

package pwsd_pkg;

  localparam int unsigned BufferBitsDefault = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RxStateW = 2;

  localparam logic [CfgW-1:0] WidthLimit = 8'hFF;

  localparam logic [CfgW-1:0] ToleranceReset = 8'd20;
  localparam logic [CfgW-1:0] StartReset = 8'd50;
  localparam logic [CfgW-1:0] DotReset = 8'd100;
  localparam logic [CfgW-1:0] DashReset = 8'd150;
  localparam logic [CfgW-1:0] StopReset = 8'd200;

  localparam logic [RxStateW-1:0] RxIdle = 2'd0;
  localparam logic [RxStateW-1:0] RxBusy = 2'd1;
  localparam logic [RxStateW-1:0] RxComplete = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTolerance = 3'd0,
    CfgStart = 3'd1,
    CfgDot = 3'd2,
    CfgDash = 3'd3,
    CfgStop = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StBusy = 3'b010,
    StComplete = 3'b100
  } recv_state_e;

  typedef struct packed {
    logic [CfgW-1:0] tolerance;
    logic [CfgW-1:0] start_w;
    logic [CfgW-1:0] dot_w;
    logic [CfgW-1:0] dash_w;
    logic [CfgW-1:0] stop_w;
  } cfg_t;

  typedef struct packed {
    logic start_hit;
    logic dot_hit;
    logic dash_hit;
    logic stop_hit;
  } hits_t;

  function automatic logic [RxStateW-1:0] rx_code(recv_state_e st);
    logic [RxStateW-1:0] code;
    case (st)
      StIdle:     code = RxIdle;
      StBusy:     code = RxBusy;
      StComplete: code = RxComplete;
      default:    code = RxIdle;
    endcase
    return code;
  endfunction

endpackage

/* src/pwsd_in_if.sv */
// pwsd_in_if: input channel carrying one line edge or take request per transfer
// depends on pwsd_pkg

interface pwsd_in_if import pwsd_pkg::*;;
  logic             valid;
  logic             ready;
  logic             mode;
  logic             line_high;
  logic [TimeW-1:0] timestamp;

  modport source (output valid, mode, line_high, timestamp, input ready);
  modport sink (input valid, mode, line_high, timestamp, output ready);
endinterface

/* src/pwsd_out_if.sv */
// pwsd_out_if: result channel, one result per accepted item
// depends on pwsd_pkg

interface pwsd_out_if import pwsd_pkg::*; #(
  parameter int unsigned BufferBits = BufferBitsDefault
);
  localparam int unsigned LenW = $clog2(BufferBits + 1);

  logic                  valid;
  logic                  ready;
  logic [RxStateW-1:0]   recv_state;
  logic                  message_valid;
  logic [BufferBits-1:0] message_bits;
  logic [LenW-1:0]       message_length;
  logic                  bit_dropped;

  modport source (output valid, recv_state, message_valid, message_bits, message_length,
                  bit_dropped, input ready);
  modport sink (input valid, recv_state, message_valid, message_bits, message_length,
                bit_dropped, output ready);
endinterface

/* src/pwsd_cfg_regs.sv */
// pwsd_cfg_regs: tolerance and nominal width registers behind the write port
// depends on pwsd_pkg

module pwsd_cfg_regs import pwsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgTolerance: cfg_d.tolerance = cfg_data_i;
        CfgStart:     cfg_d.start_w = cfg_data_i;
        CfgDot:       cfg_d.dot_w = cfg_data_i;
        CfgDash:      cfg_d.dash_w = cfg_data_i;
        CfgStop:      cfg_d.stop_w = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance <= ToleranceReset;
      cfg_q.start_w <= StartReset;
      cfg_q.dot_w <= DotReset;
      cfg_q.dash_w <= DashReset;
      cfg_q.stop_w <= StopReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/pwsd_window.sv */
// pwsd_window: compares a measured pulse width against the four tolerance windows
// depends on pwsd_pkg

module pwsd_window import pwsd_pkg::*; (
  input  logic [CfgW-1:0] width_i,
  input  cfg_t            cfg_i,
  output hits_t           hits_o
);

  // lower bound clamps at zero, so compare width + tol against nominal
  function automatic logic in_window(logic [CfgW-1:0] w, logic [CfgW-1:0] nominal,
                                     logic [CfgW-1:0] tol);
    logic [CfgW:0] w_up;
    logic [CfgW:0] hi;
    w_up = {1'b0, w} + {1'b0, tol};
    hi = {1'b0, nominal} + {1'b0, tol};
    return (w_up >= {1'b0, nominal}) && ({1'b0, w} <= hi);
  endfunction

  always_comb begin
    hits_o.start_hit = in_window(width_i, cfg_i.start_w, cfg_i.tolerance);
    hits_o.dot_hit = in_window(width_i, cfg_i.dot_w, cfg_i.tolerance);
    hits_o.dash_hit = in_window(width_i, cfg_i.dash_w, cfg_i.tolerance);
    hits_o.stop_hit = in_window(width_i, cfg_i.stop_w, cfg_i.tolerance);
  end

endmodule

/* src/pulse_width_symbol_decoder_unit.sv */
// pulse_width_symbol_decoder_unit: top level; depends on pwsd_pkg, pwsd_in_if, pwsd_out_if,
// pwsd_cfg_regs and pwsd_window
// pipeline: input register, then result register, which holds each result until it is taken
// throughput: one item per cycle; ready drops only while both registers are full and stalled
// reset: rst_ni async active low; tolerance 20, widths 50/100/150/200, receiver idle,
// start time, bit buffer and count cleared, no items in flight

module pulse_width_symbol_decoder_unit import pwsd_pkg::*; #(
  parameter int unsigned BufferBits = BufferBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pwsd_in_if.sink            in_ch,
  pwsd_out_if.source         out_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned LenW = $clog2(BufferBits + 1);
  localparam int unsigned IdxW = (BufferBits > 1) ? $clog2(BufferBits) : 1;

  cfg_t  cfg;
  hits_t hits;

  pwsd_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // input register
  logic             s1_valid_q;
  logic             mode_q;
  logic             line_high_q;
  logic [TimeW-1:0] ts_q;

  // receiver state
  recv_state_e           state_q, state_d;
  logic [TimeW-1:0]      start_q, start_d;
  logic [BufferBits-1:0] store_q, store_d;
  logic [LenW-1:0]       count_q, count_d;

  // result register
  logic                  out_valid_q;
  logic [RxStateW-1:0]   recv_state_q;
  logic                  msg_valid_q, msg_valid_d;
  logic [BufferBits-1:0] msg_bits_q, msg_bits_d;
  logic [LenW-1:0]       msg_len_q, msg_len_d;
  logic                  dropped_q, dropped_d;

  logic             s2_free;
  logic             advance;
  logic [TimeW-1:0] width;
  logic             short_pulse;

  assign s2_free = !out_valid_q || out_ch.ready;
  assign advance = s1_valid_q && s2_free;
  assign in_ch.ready = !s1_valid_q || s2_free;

  assign width = ts_q - start_q;
  assign short_pulse = width < TimeW'(WidthLimit);

  pwsd_window u_window (
    .width_i (width[CfgW-1:0]),
    .cfg_i   (cfg),
    .hits_o  (hits)
  );

  always_comb begin
    state_d = state_q;
    start_d = start_q;
    store_d = store_q;
    count_d = count_q;
    msg_valid_d = 1'b0;
    msg_bits_d = '0;
    msg_len_d = '0;
    dropped_d = 1'b0;
    if (mode_q) begin
      if (state_q == StComplete) begin
        msg_valid_d = 1'b1;
        msg_bits_d = store_q;
        msg_len_d = count_q;
        store_d = '0;
        count_d = '0;
        state_d = StIdle;
      end
    end else if (!line_high_q) begin
      start_d = ts_q;
    end else if (short_pulse) begin
      case (state_q)
        StIdle: begin
          if (hits.start_hit) state_d = StBusy;
        end
        StBusy: begin
          if (hits.stop_hit) begin
            state_d = StComplete;
          end else if (hits.dot_hit || hits.dash_hit) begin
            if (count_q < LenW'(BufferBits)) begin
              store_d[count_q[IdxW-1:0]] = !hits.dot_hit;
              count_d = count_q + LenW'(1);
            end else begin
              dropped_d = 1'b1;
            end
          end else begin
            state_d = StIdle;
          end
        end
        StComplete: state_d = state_q;
        default:    state_d = state_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q <= StIdle;
      start_q <= '0;
      store_q <= '0;
      count_q <= '0;
    end else begin
      if (in_ch.ready) s1_valid_q <= in_ch.valid;
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q <= state_d;
        start_q <= start_d;
        store_q <= store_d;
        count_q <= count_d;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      mode_q <= in_ch.mode;
      line_high_q <= in_ch.line_high;
      ts_q <= in_ch.timestamp;
    end
    if (advance) begin
      recv_state_q <= rx_code(state_d);
      msg_valid_q <= msg_valid_d;
      msg_bits_q <= msg_bits_d;
      msg_len_q <= msg_len_d;
      dropped_q <= dropped_d;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.recv_state = recv_state_q;
  assign out_ch.message_valid = msg_valid_q;
  assign out_ch.message_bits = msg_bits_q;
  assign out_ch.message_length = msg_len_q;
  assign out_ch.bit_dropped = dropped_q;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("receiver state not one-hot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LenW'(BufferBits))
    else $error("bit count beyond buffer size");

  a_msg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && msg_valid_q |-> recv_state_q == RxIdle)
    else $error("message handed out without return to idle");

  a_drop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dropped_q |-> recv_state_q == RxBusy && count_q == LenW'(BufferBits))
    else $error("dropped bit outside a full busy buffer");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> s1_valid_q && out_valid_q && !out_ch.ready)
    else $error("input stalled while a register is free");
`endif

endmodule
